/* src/slc_pkg.sv */
`default_nettype none
package slc_pkg;

    localparam int LINE_CAPACITY = 256;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = ADDR_W + 1;
    localparam int COUNT_BITS    = 24;
    localparam int OUT_BITS      = 4 * COUNT_BITS + 3;
    localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_CODE    = 2'd2;

    localparam int TOT_ALL     = 0;
    localparam int TOT_CODE    = 1;
    localparam int TOT_COMMENT = 2;
    localparam int TOT_BLANK   = 3;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_EOL  = 2'd1,
        OP_SOF  = 2'd2,
        OP_CLR  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_POST = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic post;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic early;
        logic scan_end;
    } t_dp_sts;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                      input logic en);
        sat_inc = (en && (v != {COUNT_BITS{1'b1}})) ? v + 1'b1 : v;
    endfunction

endpackage
`default_nettype wire

/* src/source_line_classifier.sv */
// Source line classifier.
// Input stream: i_s_tuser carries the operation (character, end of line,
// start of file, clear totals), i_s_tdata the character byte. Characters
// are taken one per cycle into a 256-byte line store; leading whitespace
// is dropped and bytes past the store set the truncation flag.
// An end of line produces one output word: four saturating 24-bit totals
// and the carried block-comment, open-quote and truncation flags. Other
// operations produce no word.
// Order of work: an end of line settled by the pair flags kept while storing
// goes straight to the emit state; otherwise the controller walks the
// stored line through the store's single read port, one byte a cycle,
// then takes a post step and then emits; a line comment ends the walk
// early.
// Input is not taken during that walk or until the word is loaded.
// The output register holds its word while i_m_tready is low; the block
// then still takes characters and other items, and stalls only at the
// next end of line until the word is taken.
// Reset (synchronous, active low) clears totals, flags and the counting
// mode; the line store needs no clearing.
`default_nettype none
module source_line_classifier
    import slc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // char_byte
    input  wire logic [1:0]       i_s_tuser,   // op
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // total_lines, code_lines, comment_lines, blank_lines,
    // inside_block_comment, inside_quote, line_truncated, zero pad
    output logic [OUT_W-1:0]      o_m_tdata,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_wdata  // counting_mode
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_op     op;

    assign op = t_op'(i_s_tuser);

    slc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    slc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (op),
        .i_char      (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_data      (o_m_tdata)
    );

endmodule
`default_nettype wire

/* src/slc_ctrl.sv */
`default_nettype none
module slc_ctrl
    import slc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_op     i_op,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.post     = (r_state == S_POST);
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_EOL) begin
                    n_state = i_sts.early ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_POST;
                end
            end
            S_POST: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_EOL && !i_sts.early) |=> (r_state == S_SCAN))
        else $error("end of line without early result did not start a scan");

    a_post_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST) |=> (r_state == S_EMIT))
        else $error("post step not followed by emit");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("loaded word not presented");

endmodule
`default_nettype wire

/* src/slc_dp.sv */
`default_nettype none
module slc_dp
    import slc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire t_op              i_op,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_wdata,
    output logic [OUT_W-1:0]      o_data
);

    logic [7:0]            mem [LINE_CAPACITY];
    logic [LEN_W-1:0]      r_len;
    logic                  r_past, r_ovf, r_bco, r_qo;
    logic [COUNT_BITS-1:0] r_tot [4];
    logic [1:0]            r_mode;
    logic [7:0]            r_last, r_prev;
    logic                  r_has_ss, r_has_sst, r_has_sts, r_has_q, r_c0s, r_c1s;
    logic [LEN_W-1:0]      r_k;
    logic                  r_rv;
    logic [ADDR_W-1:0]     r_ri;
    logic [7:0]            r_rdata, r_c;
    logic [1:0]            r_skip;
    logic                  r_sc, r_scode, r_ds, r_ss;
    logic [OUT_W-1:0]      r_out;

    logic m_ac, m_com, m_code;
    logic is_ws, store_ok, do_store, rd_en;
    logic none_pairs, e_blank, e_code, e_com;
    logic step, brk, n_sc, n_scode, n_ss, n_bco, n_qo;
    logic [1:0] n_skip;
    logic p_sc, p_scode, p_qo;
    logic [7:0] c, n;
    logic sts_early, sts_end;

    assign m_ac   = (r_mode == MODE_ALL) || (r_mode == MODE_COMMENT);
    assign m_com  = (r_mode == MODE_COMMENT);
    assign m_code = (r_mode == MODE_CODE);

    assign is_ws    = (i_char == CH_SP) || (i_char >= CH_TAB && i_char <= CH_CR);
    assign do_store = i_cmd.accept && (i_op == OP_CHAR) && (r_past || !is_ws);
    assign store_ok = (r_len < LEN_W'(LINE_CAPACITY));
    assign rd_en    = i_cmd.scan && (r_k < r_len);

    assign o_sts = '{early: sts_early, scan_end: sts_end};

    always_comb begin
        none_pairs = !r_has_ss && !r_has_sst && !r_has_sts;
        e_blank    = (r_len == '0);
        e_code     = 1'b0;
        e_com      = 1'b0;
        if (!e_blank) begin
            if (r_bco && !r_has_sts) begin
                e_com = 1'b1;
            end else if (none_pairs && !r_has_q) begin
                e_code = 1'b1;
            end else if (r_len >= LEN_W'(2) && r_c0s && r_c1s && !r_bco && !r_qo) begin
                e_com = 1'b1;
            end
        end
        sts_early = e_blank || e_code || e_com;
    end

    always_comb begin
        c       = r_c;
        n       = r_rdata;
        step    = r_rv && (r_ri != '0) && (r_skip == 2'd0);
        brk     = 1'b0;
        n_sc    = r_sc;
        n_scode = r_scode;
        n_ss    = r_ss;
        n_bco   = r_bco;
        n_qo    = r_qo;
        n_skip  = (r_skip != 2'd0) ? r_skip - 2'd1 : 2'd0;
        if (step) begin
            if (c == CH_SLASH && n == CH_SLASH && !r_bco && !r_qo) begin
                n_sc = r_sc || m_ac;
                brk  = 1'b1;
            end else if (c == CH_SLASH && n == CH_STAR && !r_bco && !r_qo) begin
                n_sc   = r_sc || m_ac;
                n_bco  = 1'b1;
                n_ss   = 1'b1;
                n_skip = 2'd1;
            end else if (c != CH_SP && c != CH_TAB && !r_bco) begin
                n_scode = 1'b1;
                if (c == CH_BSL) begin
                    n_skip = 2'd1;
                end else if (c == CH_SQ) begin
                    n_skip = (n == CH_BSL) ? 2'd2 : 2'd1;
                end else if (c == CH_DQ) begin
                    n_qo = !r_qo;
                end
            end else if (c == CH_STAR && n == CH_SLASH && r_bco && !r_qo) begin
                n_sc   = r_sc || m_ac;
                n_bco  = 1'b0;
                n_ss   = 1'b1;
                n_skip = 2'd1;
            end
        end
        sts_end = r_rv && (brk || ({1'b0, r_ri} == r_len - 1'b1));
    end

    always_comb begin
        p_sc    = r_sc;
        p_scode = r_scode;
        p_qo    = r_qo;
        if (r_ds) begin
            if (m_com && p_scode) p_scode = 1'b0;
            if (m_code && !p_scode) p_sc = 1'b1;
        end else if (r_last == CH_DQ && !r_bco) begin
            p_qo = !r_qo;
            if (!p_qo) p_scode = 1'b1;
        end else begin
            if (r_last != CH_SP && r_last != CH_TAB && !r_bco && r_prev != CH_STAR
                && r_last != CH_SLASH) begin
                p_scode = 1'b1;
            end
            if (r_ss) begin
                if (m_com && p_scode) p_scode = 1'b0;
                if (m_code && !p_scode && !p_sc) p_sc = 1'b1;
            end
            if (!p_sc && r_bco && m_code && !p_scode) p_sc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_store && store_ok) begin
            mem[r_len[ADDR_W-1:0]] <= i_char;
        end
        if (rd_en) begin
            r_rdata <= mem[r_k[ADDR_W-1:0]];
        end
        if (i_cmd.load_out) begin
            r_out <= {{(OUT_W-OUT_BITS){1'b0}}, r_ovf, r_qo, r_bco,
                      r_tot[TOT_BLANK], r_tot[TOT_COMMENT], r_tot[TOT_CODE], r_tot[TOT_ALL]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_past    <= 1'b0;
            r_ovf     <= 1'b0;
            r_bco     <= 1'b0;
            r_qo      <= 1'b0;
            r_mode    <= MODE_ALL;
            r_last    <= '0;
            r_prev    <= '0;
            r_has_ss  <= 1'b0;
            r_has_sst <= 1'b0;
            r_has_sts <= 1'b0;
            r_has_q   <= 1'b0;
            r_c0s     <= 1'b0;
            r_c1s     <= 1'b0;
            r_k       <= '0;
            r_rv      <= 1'b0;
            r_ri      <= '0;
            r_c       <= '0;
            r_skip    <= '0;
            r_sc      <= 1'b0;
            r_scode   <= 1'b0;
            r_ds      <= 1'b0;
            r_ss      <= 1'b0;
            for (int t = 0; t < 4; t++) begin
                r_tot[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (do_store) begin
                r_past <= 1'b1;
                if (store_ok) begin
                    r_len     <= r_len + 1'b1;
                    r_last    <= i_char;
                    r_prev    <= r_last;
                    r_has_ss  <= r_has_ss  || (r_last == CH_SLASH && i_char == CH_SLASH);
                    r_has_sst <= r_has_sst || (r_last == CH_SLASH && i_char == CH_STAR);
                    r_has_sts <= r_has_sts || (r_last == CH_STAR && i_char == CH_SLASH);
                    r_has_q   <= r_has_q || (i_char == CH_DQ);
                    if (r_len == LEN_W'(0)) r_c0s <= (i_char == CH_SLASH);
                    if (r_len == LEN_W'(1)) r_c1s <= (i_char == CH_SLASH);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.accept && i_op == OP_CLR) begin
                for (int t = 0; t < 4; t++) begin
                    r_tot[t] <= '0;
                end
            end
            if ((i_cmd.accept && i_op == OP_SOF) || i_cmd.load_out) begin
                r_len     <= '0;
                r_past    <= 1'b0;
                r_ovf     <= 1'b0;
                r_last    <= '0;
                r_prev    <= '0;
                r_has_ss  <= 1'b0;
                r_has_sst <= 1'b0;
                r_has_sts <= 1'b0;
                r_has_q   <= 1'b0;
                r_c0s     <= 1'b0;
                r_c1s     <= 1'b0;
            end
            if (i_cmd.accept && i_op == OP_SOF) begin
                r_bco <= 1'b0;
                r_qo  <= 1'b0;
            end
            if (i_cmd.accept && i_op == OP_EOL) begin
                r_tot[TOT_ALL]     <= sat_inc(r_tot[TOT_ALL], 1'b1);
                r_tot[TOT_BLANK]   <= sat_inc(r_tot[TOT_BLANK], e_blank);
                r_tot[TOT_CODE]    <= sat_inc(r_tot[TOT_CODE], e_code);
                r_tot[TOT_COMMENT] <= sat_inc(r_tot[TOT_COMMENT], e_com);
                r_k     <= '0;
                r_rv    <= 1'b0;
                r_skip  <= '0;
                r_sc    <= 1'b0;
                r_scode <= 1'b0;
                r_ds    <= 1'b0;
                r_ss    <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rv <= rd_en;
                if (rd_en) begin
                    r_k  <= r_k + 1'b1;
                    r_ri <= r_k[ADDR_W-1:0];
                end
                if (r_rv) begin
                    r_c     <= r_rdata;
                    r_skip  <= n_skip;
                    r_sc    <= n_sc;
                    r_scode <= n_scode;
                    r_ss    <= n_ss;
                    r_bco   <= n_bco;
                    r_qo    <= n_qo;
                    r_ds    <= r_ds || brk;
                end
            end
            if (i_cmd.post) begin
                r_qo               <= p_qo;
                r_tot[TOT_CODE]    <= sat_inc(r_tot[TOT_CODE], p_scode);
                r_tot[TOT_COMMENT] <= sat_inc(r_tot[TOT_COMMENT], p_sc);
            end
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire
